// ===== src/tgb_pkg.sv =====
// ============================================================================
// tgb_pkg - shared constants for the Tausworthe generator bank
// Degree limits, stream widths, reset seeds and the per-degree row tables.
// ============================================================================
package tgb_pkg;

    localparam int NUM_GEN   = 23;
    localparam int ROW_TOTAL = 483;
    localparam int WORD_W    = 32;
    localparam int DEG_W     = 6;
    localparam int GEN_W     = 5;
    localparam int S_DATA_W  = 8;   // degree_select padded to a whole byte

    localparam logic [DEG_W-1:0] DEG_MIN = 6'd10;
    localparam logic [DEG_W-1:0] DEG_MAX = 6'd32;

    localparam logic [WORD_W-1:0] SEED_TAB [NUM_GEN] = '{
        32'h2bdd4dc8, 32'hefea0845, 32'hf0501f60, 32'h7078a635, 32'hefeac8c0,
        32'h9e5945d7, 32'h5d97759f, 32'h9913a8c7, 32'h197ba92b, 32'h6adee9f8,
        32'hdcaf539d, 32'hfaf97888, 32'h72e32e5c, 32'he4dda4fe, 32'h05a42779,
        32'h3fdb4ae0, 32'he9de19ba, 32'h18349a29, 32'h3a46ca1e, 32'h45cdd9ba,
        32'hb37f795c, 32'h22b1cbd2, 32'h994b2006
    };

    // Rows of every generator, lowest degree first.
    localparam logic [WORD_W-1:0] ROW_TAB [ROW_TOTAL] = '{
        // 10
        32'he37e23cf, 32'h71bf11e7, 32'hb8df88f3, 32'hbf11e7b6, 32'hdf88f3db,
        32'h6fc479ed, 32'h37e23cf6, 32'h1bf11e7b, 32'h8df88f3d, 32'hc6fc479e,
        // 11
        32'h18ef6a58, 32'h8c77b52c, 32'hded4b0ce, 32'hef6a5867, 32'h77b52c33,
        32'h3bda9619, 32'h1ded4b0c, 32'h8ef6a586, 32'hc77b52c3, 32'h63bda961,
        32'h31ded4b0,
        // 12
        32'h5ecbd153, 32'h71ae39fa, 32'hb8d71cfd, 32'hdc6b8e7e, 32'hb0fe166c,
        32'hd87f0b36, 32'hb2f454c8, 32'hd97a2a64, 32'hecbd1532, 32'hf65e8a99,
        32'h7b2f454c, 32'hbd97a2a6,
        // 13
        32'h7098e703, 32'hc8d49482, 32'he46a4a41, 32'h82adc223, 32'h31ce0612,
        32'h98e70309, 32'h4c738184, 32'h2639c0c2, 32'h131ce061, 32'h098e7030,
        32'h84c73818, 32'hc2639c0c, 32'he131ce06,
        // 14
        32'hce6bb25c, 32'ha95e6b72, 32'h54af35b9, 32'h643c2880, 32'h321e1440,
        32'hd764b87c, 32'h6bb25c3e, 32'h35d92e1f, 32'h9aec970f, 32'hcd764b87,
        32'he6bb25c3, 32'h735d92e1, 32'h39aec970, 32'h9cd764b8,
        // 15
        32'h26c6d696, 32'hb5a5bddd, 32'hdad2deee, 32'h6d696f77, 32'h36b4b7bb,
        32'h1b5a5bdd, 32'h8dad2dee, 32'hc6d696f7, 32'h636b4b7b, 32'hb1b5a5bd,
        32'hd8dad2de, 32'h6c6d696f, 32'h3636b4b7, 32'h9b1b5a5b, 32'h4d8dad2d,
        // 16
        32'hd14d37b6, 32'h68a69bdb, 32'h651e7a5b, 32'he3c20a9b, 32'h71e1054d,
        32'h69bdb510, 32'h34deda88, 32'h9a6f6d44, 32'h4d37b6a2, 32'ha69bdb51,
        32'h534deda8, 32'h29a6f6d4, 32'h14d37b6a, 32'h8a69bdb5, 32'h4534deda,
        32'ha29a6f6d,
        // 17
        32'hf24d3012, 32'hf9269809, 32'h7c934c04, 32'h4c049610, 32'ha6024b08,
        32'hd3012584, 32'h698092c2, 32'h34c04961, 32'h9a6024b0, 32'h4d301258,
        32'h2698092c, 32'h934c0496, 32'h49a6024b, 32'h24d30125, 32'h92698092,
        32'hc934c049, 32'he49a6024,
        // 18
        32'hd324d053, 32'h69926829, 32'hb4c93414, 32'h5a649a0a, 32'had324d05,
        32'hd6992682, 32'heb4c9341, 32'h268299f3, 32'h93414cf9, 32'h49a0a67c,
        32'h24d0533e, 32'h9268299f, 32'hc93414cf, 32'h649a0a67, 32'h324d0533,
        32'h99268299, 32'h4c93414c, 32'ha649a0a6,
        // 19
        32'h67b65819, 32'hd46d7415, 32'h8d80e213, 32'hc6c07109, 32'he3603884,
        32'h9606445b, 32'hcb03222d, 32'h65819116, 32'hb2c0c88b, 32'hd9606445,
        32'h6cb03222, 32'hb6581911, 32'hdb2c0c88, 32'hed960644, 32'hf6cb0322,
        32'h7b658191, 32'h3db2c0c8, 32'h9ed96064, 32'hcf6cb032,
        // 20
        32'h8885acca, 32'h4442d665, 32'ha2216b32, 32'h59951953, 32'hacca8ca9,
        32'hd6654654, 32'h6b32a32a, 32'hb5995195, 32'h5acca8ca, 32'h2d665465,
        32'h16b32a32, 32'h0b599519, 32'h85acca8c, 32'h42d66546, 32'h216b32a3,
        32'h10b59951, 32'h885acca8, 32'h442d6654, 32'h2216b32a, 32'h110b5995,
        // 21
        32'h52eee0ca, 32'ha9777065, 32'h065558f8, 32'h832aac7c, 32'hc195563e,
        32'he0caab1f, 32'h7065558f, 32'hb832aac7, 32'hdc195563, 32'hee0caab1,
        32'h77065558, 32'hbb832aac, 32'hddc19556, 32'heee0caab, 32'h77706555,
        32'hbbb832aa, 32'h5ddc1955, 32'h2eee0caa, 32'h97770655, 32'h4bbb832a,
        32'ha5ddc195,
        // 22
        32'h114ccccf, 32'h99eaaaa8, 32'hccf55554, 32'h667aaaaa, 32'h333d5555,
        32'h999eaaaa, 32'hcccf5555, 32'h6667aaaa, 32'h3333d555, 32'h9999eaaa,
        32'hccccf555, 32'h66667aaa, 32'h33333d55, 32'h99999eaa, 32'h4ccccf55,
        32'ha66667aa, 32'h533333d5, 32'h299999ea, 32'h14ccccf5, 32'h8a66667a,
        32'h4533333d, 32'h2299999e,
        // 23
        32'h45a2e7e3, 32'ha2d173f1, 32'hd168b9f8, 32'h68b45cfc, 32'hb45a2e7e,
        32'h9f8ff0dc, 32'hcfc7f86e, 32'he7e3fc37, 32'h73f1fe1b, 32'hb9f8ff0d,
        32'h5cfc7f86, 32'h2e7e3fc3, 32'h173f1fe1, 32'h8b9f8ff0, 32'h45cfc7f8,
        32'ha2e7e3fc, 32'hd173f1fe, 32'h68b9f8ff, 32'hb45cfc7f, 32'h5a2e7e3f,
        32'h2d173f1f, 32'h168b9f8f, 32'h8b45cfc7,
        // 24
        32'h0d36bbad, 32'h8bade67b, 32'hc5d6f33d, 32'h6fddc233, 32'hbad85ab4,
        32'hdd6c2d5a, 32'heeb616ad, 32'h775b0b56, 32'hbbad85ab, 32'h5dd6c2d5,
        32'haeeb616a, 32'hd775b0b5, 32'h6bbad85a, 32'hb5dd6c2d, 32'hdaeeb616,
        32'h6d775b0b, 32'h36bbad85, 32'h9b5dd6c2, 32'h4daeeb61, 32'ha6d775b0,
        32'hd36bbad8, 32'h69b5dd6c, 32'h34daeeb6, 32'h1a6d775b,
        // 25
        32'hc156e5e5, 32'he0ab72f2, 32'h7055b979, 32'h797c3959, 32'hbcbe1cac,
        32'h5e5f0e56, 32'h2f2f872b, 32'h9797c395, 32'hcbcbe1ca, 32'he5e5f0e5,
        32'h72f2f872, 32'hb9797c39, 32'hdcbcbe1c, 32'h6e5e5f0e, 32'hb72f2f87,
        32'h5b9797c3, 32'hadcbcbe1, 32'h56e5e5f0, 32'hab72f2f8, 32'h55b9797c,
        32'h2adcbcbe, 32'h156e5e5f, 32'h0ab72f2f, 32'h055b9797, 32'h82adcbcb,
        // 26
        32'h3e7263c9, 32'h214b522d, 32'h2ed7cadf, 32'h176be56f, 32'h0bb5f2b7,
        32'h05daf95b, 32'h3c9f1f64, 32'h1e4f8fb2, 32'h8f27c7d9, 32'hc793e3ec,
        32'h63c9f1f6, 32'h31e4f8fb, 32'h98f27c7d, 32'h4c793e3e, 32'h263c9f1f,
        32'h931e4f8f, 32'hc98f27c7, 32'he4c793e3, 32'h7263c9f1, 32'h3931e4f8,
        32'h9c98f27c, 32'hce4c793e, 32'he7263c9f, 32'hf3931e4f, 32'hf9c98f27,
        32'h7ce4c793,
        // 27
        32'ha19fa5ea, 32'hf150771f, 32'hd9379e65, 32'h6c9bcf32, 32'hb64de799,
        32'h7ab95626, 32'hbd5cab13, 32'h5eae5589, 32'h2f572ac4, 32'h97ab9562,
        32'h4bd5cab1, 32'ha5eae558, 32'hd2f572ac, 32'he97ab956, 32'hf4bd5cab,
        32'hfa5eae55, 32'hfd2f572a, 32'h7e97ab95, 32'h3f4bd5ca, 32'h9fa5eae5,
        32'hcfd2f572, 32'h67e97ab9, 32'h33f4bd5c, 32'h19fa5eae, 32'h0cfd2f57,
        32'h867e97ab, 32'h433f4bd5,
        // 28
        32'hc4c15e7e, 32'he260af3f, 32'h7130579f, 32'hfc5975b1, 32'h7e2cbad8,
        32'h3f165d6c, 32'h9f8b2eb6, 32'hcfc5975b, 32'he7e2cbad, 32'hf3f165d6,
        32'h79f8b2eb, 32'hbcfc5975, 32'h5e7e2cba, 32'haf3f165d, 32'h579f8b2e,
        32'h2bcfc597, 32'h15e7e2cb, 32'h0af3f165, 32'h0579f8b2, 32'h82bcfc59,
        32'hc15e7e2c, 32'h60af3f16, 32'h30579f8b, 32'h982bcfc5, 32'h4c15e7e2,
        32'h260af3f1, 32'h130579f8, 32'h8982bcfc,
        // 29
        32'h27d1c585, 32'h13e8e2c2, 32'h2e25b4e4, 32'h1712da72, 32'h0b896d39,
        32'h85c4b69c, 32'hc2e25b4e, 32'h61712da7, 32'hb0b896d3, 32'h585c4b69,
        32'h2c2e25b4, 32'h161712da, 32'h8b0b896d, 32'hc585c4b6, 32'he2c2e25b,
        32'h7161712d, 32'h38b0b896, 32'h1c585c4b, 32'h8e2c2e25, 32'h47161712,
        32'ha38b0b89, 32'hd1c585c4, 32'he8e2c2e2, 32'hf4716171, 32'hfa38b0b8,
        32'h7d1c585c, 32'h3e8e2c2e, 32'h9f471617, 32'h4fa38b0b,
        // 30
        32'hde941dc4, 32'hb1de1326, 32'hd8ef0993, 32'h6c7784c9, 32'h68afdfa0,
        32'h3457efd0, 32'hc4bfea2c, 32'he25ff516, 32'h712ffa8b, 32'hb897fd45,
        32'hdc4bfea2, 32'hee25ff51, 32'h7712ffa8, 32'h3b897fd4, 32'h1dc4bfea,
        32'h0ee25ff5, 32'h07712ffa, 32'h83b897fd, 32'h41dc4bfe, 32'ha0ee25ff,
        32'h507712ff, 32'h283b897f, 32'h941dc4bf, 32'h4a0ee25f, 32'ha507712f,
        32'hd283b897, 32'he941dc4b, 32'hf4a0ee25, 32'h7a507712, 32'hbd283b89,
        // 31
        32'h51c2ce85, 32'h28e16742, 32'h1470b3a1, 32'h5bfa9755, 32'h2dfd4baa,
        32'h16fea5d5, 32'h0b7f52ea, 32'h85bfa975, 32'h42dfd4ba, 32'ha16fea5d,
        32'hd0b7f52e, 32'he85bfa97, 32'h742dfd4b, 32'h3a16fea5, 32'h9d0b7f52,
        32'hce85bfa9, 32'h6742dfd4, 32'hb3a16fea, 32'h59d0b7f5, 32'h2ce85bfa,
        32'h16742dfd, 32'h0b3a16fe, 32'h859d0b7f, 32'hc2ce85bf, 32'he16742df,
        32'h70b3a16f, 32'h3859d0b7, 32'h1c2ce85b, 32'h8e16742d, 32'h470b3a16,
        32'ha3859d0b,
        // 32
        32'h82fb4d95, 32'h417da6ca, 32'h22459ef0, 32'h9122cf78, 32'h489167bc,
        32'ha448b3de, 32'h50df147a, 32'h2a94c7a8, 32'h954a63d4, 32'hcaa531ea,
        32'h655298f5, 32'hb2a94c7a, 32'hd954a63d, 32'h6caa531e, 32'h3655298f,
        32'h9b2a94c7, 32'h4d954a63, 32'ha6caa531, 32'hd3655298, 32'h69b2a94c,
        32'hb4d954a6, 32'hda6caa53, 32'hed365529, 32'hf69b2a94, 32'hfb4d954a,
        32'h7da6caa5, 32'hbed36552, 32'h5f69b2a9, 32'h2fb4d954, 32'h17da6caa,
        32'h0bed3655, 32'h05f69b2a
    };

    // Row r of generator g (degree g+10); zero past the generator's degree.
    function automatic logic [WORD_W-1:0] gen_row(input int g, input int r);
        logic [WORD_W-1:0] w;
        w = '0;
        if (r < g + 10)
        begin
            w = ROW_TAB[(g * (g + 19)) / 2 + r];
        end
        return w;
    endfunction

endpackage

// ===== src/tausworthe_generator_bank.sv =====
// ============================================================================
// tausworthe_generator_bank - bank of 23 GF(2) matrix generators
// Steps the generator of the requested degree and returns its new state.
// ============================================================================
// Usage:
//   Slave stream carries requests: s_tdata[5:0] is the degree (10..32), the
//   upper bits are ignored. Master stream returns one transaction per
//   request: m_tdata is the new 32-bit state, m_tuser flags a bad degree
//   (then m_tdata is zero and no generator moves).
//   The request register loads on the accepting edge and the XOR tree feeds
//   the result register when the request advances, which raises m_tvalid.
//   Throughput is one request per cycle while the receiver does not stall;
//   the state write-back happens in the same cycle the result register
//   loads, so consecutive requests to one degree chain correctly.
//   When the receiver stalls, the result register holds and the request
//   register still takes one more request; s_tready drops once both are
//   full.
//   Reset loads every generator with its seed and empties both registers.
// ============================================================================
module tausworthe_generator_bank (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tgb_pkg::S_DATA_W-1:0]   s_tdata,   // [5:0] degree_select, [7:6] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tgb_pkg::WORD_W-1:0]     m_tdata,   // [31:0] random_word
    output logic                           m_tuser    // [0] bad_degree
);
    import tgb_pkg::*;

    logic                in_valid_reg;
    logic [DEG_W-1:0]    deg_reg;
    logic                out_valid_reg;
    logic [WORD_W-1:0]   word_reg;
    logic                bad_reg;
    logic [WORD_W-1:0]   state_reg [NUM_GEN];

    logic                advance;
    logic                deg_ok;
    logic [GEN_W-1:0]    gen_idx;
    logic [WORD_W-1:0]   cur_state;
    logic [WORD_W-1:0]   lane_word [WORD_W];
    logic [WORD_W-1:0]   acc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign deg_ok    = (deg_reg >= DEG_MIN) && (deg_reg <= DEG_MAX);
    assign gen_idx   = deg_ok ? GEN_W'(deg_reg - DEG_MIN) : '0;
    assign cur_state = state_reg[gen_idx];

    // One lane per state bit: bit 31-r selects row r of the chosen generator.
    for (genvar r = 0; r < WORD_W; r++)
    begin : g_lane
        logic [WORD_W-1:0] lane_rows [NUM_GEN];
        for (genvar g = 0; g < NUM_GEN; g++)
        begin : g_row
            assign lane_rows[g] = gen_row(g, r);
        end
        assign lane_word[r] = cur_state[WORD_W-1-r] ? lane_rows[gen_idx] : '0;
    end

    always_comb
    begin
        acc = '0;
        for (int r = 0; r < WORD_W; r++)
        begin
            acc = acc ^ lane_word[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int g = 0; g < NUM_GEN; g++)
            begin
                state_reg[g] <= SEED_TAB[g];
            end
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance && deg_ok)
            begin
                state_reg[gen_idx] <= acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            deg_reg <= s_tdata[DEG_W-1:0];
        end
        if (advance)
        begin
            word_reg <= deg_ok ? acc : '0;
            bad_reg  <= !deg_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = bad_reg;

endmodule
